/* design/nnr_pkg.sv */
// nnr_pkg: shared types, field widths, register codes and defaults for the
// nearest neighbor channel remap block. Depends on nothing; the top level,
// nnr_csr and nnr_store refer to it by scoped names.
package nnr_pkg;

   // default sizing of the top level
   localparam int MAX_SRC_SIDE_DEF = 256;
   localparam int MAX_DST_SIDE_DEF = 4096;
   localparam int FRAC_BITS_DEF    = 16;

   // fixed field widths
   localparam int SRC_SIZE_W = 9;
   localparam int DST_SIZE_W = 13;
   localparam int CHAN_CNT_W = 3;
   localparam int CHAN_SEL_W = 2;
   localparam int PIXEL_W    = 8;
   localparam int COORD_W    = 12;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

   // csr port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SRC_CHANNELS = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PICK_CHANNEL = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_INVERT       = 3'd6;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // channel selection codes
   localparam logic [CHAN_SEL_W-1:0] CHAN_RED   = 2'd0;
   localparam logic [CHAN_SEL_W-1:0] CHAN_GREEN = 2'd1;
   localparam logic [CHAN_SEL_W-1:0] CHAN_BLUE  = 2'd2;
   localparam logic [CHAN_SEL_W-1:0] CHAN_ALPHA = 2'd3;

   typedef struct packed {
      logic               command;
      logic [PIXEL_W-1:0] chan0;
      logic [PIXEL_W-1:0] chan1;
      logic [PIXEL_W-1:0] chan2;
      logic [PIXEL_W-1:0] chan3;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [PIXEL_W-1:0] out_value;
      logic               out_last;
   } rsp_type;

   typedef struct packed {
      logic [SRC_SIZE_W-1:0] src_width;
      logic [SRC_SIZE_W-1:0] src_height;
      logic [DST_SIZE_W-1:0] dst_width;
      logic [DST_SIZE_W-1:0] dst_height;
      logic [CHAN_CNT_W-1:0] src_channels;
      logic [CHAN_SEL_W-1:0] pick_channel;
      logic                  invert;
   } cfg_type;

endpackage

/* design/nearest_neighbor_channel_remap.sv */
// nearest_neighbor_channel_remap: top level of the nearest neighbor scaler
// that keeps one channel of the source image. Depends on nnr_pkg, nnr_csr,
// nnr_div and nnr_store.
//
// Usage: the req channel carries load and emit transactions. A load writes
// the selected channel byte (or 0 when that channel is absent) of one source
// pixel into the source memory in raster order, and returns nothing. An emit
// produces the next destination pixel on the rsp channel, with its column,
// row, sampled value and a last flag on the final pixel of the frame.
// An emit passes through a multiply stage, an address stage, the memory
// read and the output register, one transaction at a time: no new
// transaction is taken until the emit has moved into the output register.
// A csr write to any listed register restarts the two scale-step dividers,
// which produce one quotient bit a cycle; req_ready stays low while the
// write is pending and while either divider is busy.
// Reset clears the counters and load pointer and resets the registers; the steps
// take their reset value at once, so no pass over the memory is needed.
// When rsp_ready is low, a result waits in the output register; loads are
// still taken meanwhile, and a following emit waits in its last stage.
module nearest_neighbor_channel_remap #(
   parameter int MAX_SRC_SIDE = nnr_pkg::MAX_SRC_SIDE_DEF,
   parameter int MAX_DST_SIDE = nnr_pkg::MAX_DST_SIDE_DEF,
   parameter int FRAC_BITS    = nnr_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nnr_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nnr_pkg::rsp_type                rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nnr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [nnr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [nnr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int SRC_W  = $clog2(MAX_SRC_SIDE + 1);
   localparam int DST_W  = $clog2(MAX_DST_SIDE + 1);
   localparam int XW     = (MAX_SRC_SIDE > 2) ? $clog2(MAX_SRC_SIDE) : 1;
   localparam int CNT_W  = $clog2(MAX_DST_SIDE);
   localparam int NW     = CNT_W + 1;
   localparam int STEP_W = SRC_W + FRAC_BITS;
   localparam int PW     = CNT_W + STEP_W;
   localparam int SXW    = PW - FRAC_BITS;
   localparam int MW     = XW + SRC_W;
   localparam int FRM_W  = 2 * SRC_W;
   localparam int DEPTH  = MAX_SRC_SIDE * MAX_SRC_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int PIX_W  = nnr_pkg::PIXEL_W;
   localparam int OUT_W  = nnr_pkg::COORD_W;
   localparam int CH_W   = nnr_pkg::CHAN_CNT_W;
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'((1 << FRAC_BITS) + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ADDR = 5'b00100,
      ST_READ = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   nnr_pkg::cfg_type cfg;
   logic             cfg_wr;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0] cur_x_ff, cur_y_ff;
   logic             last_ff;
   logic [PW-1:0]    prod_x_ff, prod_y_ff;
   logic [AW-1:0]    addr_ff;
   logic [FRM_W-1:0] frame_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   nnr_pkg::rsp_type rsp_ff;

   logic [SRC_W-1:0]  sw_eff, sh_eff;
   logic [DST_W-1:0]  dw_eff, dh_eff;
   logic [STEP_W-1:0] x_step, y_step;
   logic              x_busy, y_busy;

   logic              req_acc, is_load, is_emit;
   logic [PIX_W-1:0]  load_val, chan_pick, rd_data, out_val;
   logic [AW-1:0]     ptr_use;
   logic [FRM_W-1:0]  ptr_inc;
   logic [NW-1:0]     dw_ext, dh_ext, col_ext, row_ext, col_inc;
   logic [CNT_W-1:0]  col_use, row_use;
   logic              frame_out, last_now;
   logic [SXW-1:0]    sx_full, sy_full;
   logic [XW-1:0]     sx_cl, sy_cl;
   logic [MW-1:0]     addr_sum;
   logic              out_free;

   nnr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   // effective sizes: zero acts as one, oversize saturates
   always_comb begin
      if (cfg.src_width == '0) begin
         sw_eff = SRC_W'(1);
      end else if (32'(cfg.src_width) > MAX_SRC_SIDE) begin
         sw_eff = SRC_W'(MAX_SRC_SIDE);
      end else begin
         sw_eff = SRC_W'(cfg.src_width);
      end
      if (cfg.src_height == '0) begin
         sh_eff = SRC_W'(1);
      end else if (32'(cfg.src_height) > MAX_SRC_SIDE) begin
         sh_eff = SRC_W'(MAX_SRC_SIDE);
      end else begin
         sh_eff = SRC_W'(cfg.src_height);
      end
      if (cfg.dst_width == '0) begin
         dw_eff = DST_W'(1);
      end else if (32'(cfg.dst_width) > MAX_DST_SIDE) begin
         dw_eff = DST_W'(MAX_DST_SIDE);
      end else begin
         dw_eff = DST_W'(cfg.dst_width);
      end
      if (cfg.dst_height == '0) begin
         dh_eff = DST_W'(1);
      end else if (32'(cfg.dst_height) > MAX_DST_SIDE) begin
         dh_eff = DST_W'(MAX_DST_SIDE);
      end else begin
         dh_eff = DST_W'(cfg.dst_height);
      end
   end

   // scale step dividers, restarted after each write to a listed register
   nnr_div #(
      .NUM_W      (STEP_W),
      .DEN_W      (DST_W),
      .STEP_RESET (STEP_RESET)
   ) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (cfg_wr),
      .num   ({sw_eff, {FRAC_BITS{1'b0}}}),
      .den   (dw_eff),
      .busy  (x_busy),
      .step  (x_step)
   );

   nnr_div #(
      .NUM_W      (STEP_W),
      .DEN_W      (DST_W),
      .STEP_RESET (STEP_RESET)
   ) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (cfg_wr),
      .num   ({sh_eff, {FRAC_BITS{1'b0}}}),
      .den   (dh_eff),
      .busy  (y_busy),
      .step  (y_step)
   );

   // request handshake
   assign req_ready = (state_ff == ST_IDLE) & ~cfg_wr & ~x_busy & ~y_busy;
   assign req_acc   = req_valid & req_ready;
   assign is_load   = req_acc & (req_payload.command == nnr_pkg::CMD_LOAD);
   assign is_emit   = req_acc & (req_payload.command == nnr_pkg::CMD_EMIT);

   // channel pick for a load
   always_comb begin
      case (cfg.pick_channel)
         nnr_pkg::CHAN_RED:   chan_pick = req_payload.chan0;
         nnr_pkg::CHAN_GREEN: chan_pick = req_payload.chan1;
         nnr_pkg::CHAN_BLUE:  chan_pick = req_payload.chan2;
         nnr_pkg::CHAN_ALPHA: chan_pick = req_payload.chan3;
         default:             chan_pick = req_payload.chan0;
      endcase
      load_val = (CH_W'(cfg.pick_channel) < cfg.src_channels) ? chan_pick : '0;
   end

   // load pointer, wraps at the source frame size
   always_comb begin
      ptr_use = (FRM_W'(ptr_ff) >= frame_ff) ? '0 : ptr_ff;
      ptr_inc = FRM_W'(ptr_use) + FRM_W'(1);
      ptr_in  = ptr_ff;
      if (is_load) begin
         ptr_in = (ptr_inc >= frame_ff) ? '0 : AW'(ptr_inc);
      end
   end

   // destination counters, advanced when an emit is taken
   always_comb begin
      dw_ext    = NW'(dw_eff);
      dh_ext    = NW'(dh_eff);
      col_ext   = NW'(col_ff);
      row_ext   = NW'(row_ff);
      frame_out = (col_ext >= dw_ext) | (row_ext >= dh_ext);
      col_use   = frame_out ? '0 : col_ff;
      row_use   = frame_out ? '0 : row_ff;
      col_inc   = NW'(col_use) + NW'(1);
      last_now  = (NW'(col_use) == dw_ext - NW'(1)) & (NW'(row_use) == dh_ext - NW'(1));
      col_in    = col_ff;
      row_in    = row_ff;
      if (is_emit) begin
         if (last_now) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= dw_ext) begin
            col_in = '0;
            row_in = row_use + CNT_W'(1);
         end else begin
            col_in = CNT_W'(col_inc);
            row_in = row_use;
         end
      end
   end

   // clamp the scaled coordinates and form the store address
   always_comb begin
      sx_full  = prod_x_ff[PW-1:FRAC_BITS];
      sy_full  = prod_y_ff[PW-1:FRAC_BITS];
      sx_cl    = (sx_full > SXW'(sw_eff - SRC_W'(1))) ? XW'(sw_eff - SRC_W'(1))
                                                       : XW'(sx_full);
      sy_cl    = (sy_full > SXW'(sh_eff - SRC_W'(1))) ? XW'(sh_eff - SRC_W'(1))
                                                       : XW'(sy_full);
      addr_sum = MW'(sy_cl) * MW'(sw_eff) + MW'(sx_cl);
   end

   // emit sequencer
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (is_emit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ADDR;
         ST_ADDR: state_in = ST_READ;
         ST_READ: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_val = cfg.invert ? (nnr_pkg::PIXEL_MAX - rd_data) : rd_data;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         frame_ff     <= FRM_W'(1);
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         frame_ff     <= FRM_W'(sw_eff) * FRM_W'(sh_eff);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (is_emit) begin
         cur_x_ff <= col_use;
         cur_y_ff <= row_use;
         last_ff  <= last_now;
      end
      if (state_ff == ST_MUL) begin
         prod_x_ff <= PW'(cur_x_ff) * PW'(x_step);
         prod_y_ff <= PW'(cur_y_ff) * PW'(y_step);
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= AW'(addr_sum);
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_ff.out_x     <= OUT_W'(cur_x_ff);
         rsp_ff.out_y     <= OUT_W'(cur_y_ff);
         rsp_ff.out_value <= out_val;
         rsp_ff.out_last  <= last_ff;
      end
   end

   nnr_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (is_load),
      .wr_addr (ptr_use),
      .wr_data (load_val),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/nnr_csr.sv */
// nnr_csr: apb-style configuration registers of the channel remap block.
// Depends on nnr_pkg for the register codes, widths and the cfg_type struct.
module nnr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nnr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [nnr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [nnr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output nnr_pkg::cfg_type                    cfg,
   output logic                                cfg_wr
);

   localparam int SW = nnr_pkg::SRC_SIZE_W;
   localparam int DW = nnr_pkg::DST_SIZE_W;
   localparam int CW = nnr_pkg::CHAN_CNT_W;
   localparam int SELW = nnr_pkg::CHAN_SEL_W;
   localparam int DATA_W = nnr_pkg::CSR_DATA_W;

   nnr_pkg::cfg_type cfg_ff, cfg_in;
   logic cfg_wr_in;
   logic wr_en;
   logic [nnr_pkg::REG_IDX_W-1:0] reg_idx;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[nnr_pkg::CSR_ADDR_W-1:2];

   // register write decode
   always_comb begin
      cfg_in    = cfg_ff;
      cfg_wr_in = 1'b0;
      if (wr_en) begin
         cfg_wr_in = 1'b1;
         case (reg_idx)
            nnr_pkg::REG_SRC_WIDTH:    cfg_in.src_width    = csr_pwdata[SW-1:0];
            nnr_pkg::REG_SRC_HEIGHT:   cfg_in.src_height   = csr_pwdata[SW-1:0];
            nnr_pkg::REG_DST_WIDTH:    cfg_in.dst_width    = csr_pwdata[DW-1:0];
            nnr_pkg::REG_DST_HEIGHT:   cfg_in.dst_height   = csr_pwdata[DW-1:0];
            nnr_pkg::REG_SRC_CHANNELS: cfg_in.src_channels = csr_pwdata[CW-1:0];
            nnr_pkg::REG_PICK_CHANNEL: cfg_in.pick_channel = csr_pwdata[SELW-1:0];
            nnr_pkg::REG_INVERT:       cfg_in.invert       = csr_pwdata[0];
            default:                   cfg_wr_in           = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width    <= SW'(1);
         cfg_ff.src_height   <= SW'(1);
         cfg_ff.dst_width    <= DW'(1);
         cfg_ff.dst_height   <= DW'(1);
         cfg_ff.src_channels <= CW'(4);
         cfg_ff.pick_channel <= nnr_pkg::CHAN_RED;
         cfg_ff.invert       <= 1'b0;
         cfg_wr              <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         cfg_wr <= cfg_wr_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         nnr_pkg::REG_SRC_WIDTH:    csr_prdata = DATA_W'(cfg_ff.src_width);
         nnr_pkg::REG_SRC_HEIGHT:   csr_prdata = DATA_W'(cfg_ff.src_height);
         nnr_pkg::REG_DST_WIDTH:    csr_prdata = DATA_W'(cfg_ff.dst_width);
         nnr_pkg::REG_DST_HEIGHT:   csr_prdata = DATA_W'(cfg_ff.dst_height);
         nnr_pkg::REG_SRC_CHANNELS: csr_prdata = DATA_W'(cfg_ff.src_channels);
         nnr_pkg::REG_PICK_CHANNEL: csr_prdata = DATA_W'(cfg_ff.pick_channel);
         nnr_pkg::REG_INVERT:       csr_prdata = DATA_W'(cfg_ff.invert);
         default:                   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

/* design/nnr_div.sv */
// nnr_div: restoring divider, one quotient bit per cycle, that produces the
// fixed-point scale step (quotient plus one). Depends on no package items.
module nnr_div #(
   parameter int              NUM_W      = 25,
   parameter int              DEN_W      = 13,
   parameter logic [NUM_W-1:0] STEP_RESET = '0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] step
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [NUM_W-1:0] step_ff;

   logic [DEN_W:0]   rem_sh;
   logic             q_bit;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quot_in;

   // one shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      q_bit   = rem_sh >= {1'b0, den_ff};
      rem_in  = q_bit ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
      quot_in = {num_ff[NUM_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_RESET;
      end else if (start) begin
         busy_ff <= 1'b1;
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         num_ff <= quot_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            step_ff <= quot_in + NUM_W'(1);
         end
      end
   end

   assign busy = busy_ff;
   assign step = step_ff;

endmodule

/* design/nnr_store.sv */
// nnr_store: single-port-write, registered-read source pixel memory.
// Depends on nnr_pkg for the pixel width.
module nnr_store #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [nnr_pkg::PIXEL_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [nnr_pkg::PIXEL_W-1:0]   rd_data
);

   logic [nnr_pkg::PIXEL_W-1:0] store_ff [DEPTH];
   logic [nnr_pkg::PIXEL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
